@@ design/rte_pkg.sv @@
// Shared constants, types and saturation helpers for the rigid transform engine.
`default_nettype none

package rte_pkg;

   // Number format and matrix geometry.
   localparam int FRAC_BITS   = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int COORD_W     = 32;
   localparam int FUNC_W      = 2;
   localparam int ROW_W       = 2;
   localparam int COL_W       = 2;
   localparam int ROWS        = 3;
   localparam int COLS        = 4;
   localparam int T_COL       = COLS - 1;
   localparam int ENTRIES     = ROWS * COLS;
   localparam int IDX_W       = $clog2(ENTRIES);

   // Multiplier operand B carries either a coordinate or a negated translation entry.
   localparam int MUL_B_W = (VALUE_WIDTH + 1 > COORD_W) ? VALUE_WIDTH + 1 : COORD_W;
   localparam int PROD_W  = VALUE_WIDTH + MUL_B_W;
   localparam int TERM_W  = PROD_W - FRAC_BITS;
   localparam int SUM_W   = TERM_W + 2;
   localparam int LOAD_W  = ((VALUE_WIDTH > COORD_W) ? VALUE_WIDTH : COORD_W) + 1;

   // Queue between the front and the back.
   localparam int QPTR_W      = 2;
   localparam int QUEUE_DEPTH = 2 ** QPTR_W;
   localparam int QCNT_W      = QPTR_W + 1;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic signed [COORD_W-1:0]     coord_type;
   typedef logic signed [TERM_W-1:0]      term_type;
   typedef logic signed [SUM_W-1:0]       sum_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD    = 2'd0,
      FUNC_POINT   = 2'd1,
      FUNC_VECTOR  = 2'd2,
      FUNC_INVERSE = 2'd3
   } func_type;

   // One classified word as it sits in the queue.
   typedef struct packed {
      func_type             func;
      logic [IDX_W-1:0]     idx;
      value_type            value;
      coord_type            x;
      coord_type            y;
      coord_type            z;
   } item_type;

   typedef struct packed {
      value_type value;
      logic      ovf;
   } sat_type;

   localparam value_type VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   // 1.0 in the fixed-point format, or the largest value when 1.0 does not fit.
   localparam value_type ONE_VALUE =
      (FRAC_BITS < VALUE_WIDTH - 1) ? (value_type'(1) << FRAC_BITS) : VALUE_MAX;

   // Clamp an exact sum to the stored value width.
   function automatic sat_type sat_sum(input sum_type s);
      sat_type                    r;
      logic [SUM_W-VALUE_WIDTH:0] top;
      top = s[SUM_W-1:VALUE_WIDTH-1];
      if ((&top) || !(|top)) begin
         r.value = s[VALUE_WIDTH-1:0];
         r.ovf   = 1'b0;
      end else begin
         r.value = s[SUM_W-1] ? VALUE_MIN : VALUE_MAX;
         r.ovf   = 1'b1;
      end
      return r;
   endfunction

   // Clamp a loaded coordinate-width value to the stored value width.
   function automatic value_type sat_load(input coord_type c);
      value_type                   r;
      logic signed [LOAD_W-1:0]    w;
      logic [LOAD_W-VALUE_WIDTH:0] top;
      w   = LOAD_W'(c);
      top = w[LOAD_W-1:VALUE_WIDTH-1];
      if ((&top) || !(|top)) begin
         r = w[VALUE_WIDTH-1:0];
      end else begin
         r = w[LOAD_W-1] ? VALUE_MIN : VALUE_MAX;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ design/rte_if.sv @@
// Request and response channel interfaces of the rigid transform engine.
`default_nettype none

interface rte_req_if import rte_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [FUNC_W-1:0] func;
   logic [ROW_W-1:0] row_index;
   logic [COL_W-1:0] col_index;
   coord_type        entry_value;
   coord_type        point_x;
   coord_type        point_y;
   coord_type        point_z;

   modport source (
      output valid, func, row_index, col_index, entry_value, point_x, point_y, point_z,
      input  ready
   );
   modport sink (
      input  valid, func, row_index, col_index, entry_value, point_x, point_y, point_z,
      output ready
   );
endinterface

interface rte_rsp_if import rte_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type out_x;
   coord_type out_y;
   coord_type out_z;
   logic      overflow;

   modport source (
      output valid, out_x, out_y, out_z, overflow,
      input  ready
   );
   modport sink (
      input  valid, out_x, out_y, out_z, overflow,
      output ready
   );
endinterface

`default_nettype wire

@@ design/rte_front.sv @@
// Front end: takes request words, drops loads aimed past the last row, prepares queue words.
`default_nettype none

module rte_front import rte_pkg::*; (
   rte_req_if.sink  req,
   output logic     enq_valid,
   output item_type enq_item,
   input  logic     enq_ready
);

   func_type func;
   logic     drop;

   always_comb begin
      func = func_type'(req.func);
      drop = (func == FUNC_LOAD) && (req.row_index >= ROW_W'(ROWS));

      req.ready = enq_ready;
      enq_valid = req.valid && !drop;

      enq_item.func  = func;
      enq_item.idx   = IDX_W'(int'(req.row_index) * COLS + int'(req.col_index));
      enq_item.value = sat_load(req.entry_value);
      enq_item.x     = req.point_x;
      enq_item.y     = req.point_y;
      enq_item.z     = req.point_z;
   end

endmodule

`default_nettype wire

@@ design/rte_queue.sv @@
// Small first-in first-out queue that decouples the front from the back.
`default_nettype none

module rte_queue import rte_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     enq_valid,
   input  item_type enq_item,
   output logic     enq_ready,
   output logic     deq_valid,
   output item_type deq_item,
   input  logic     deq_ready
);

   item_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;

   always_comb begin
      enq_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
      deq_valid = count_ff != '0;
      deq_item  = slot_ff[rd_ptr_ff];
      push      = enq_valid && enq_ready;
      pop       = deq_valid && deq_ready;
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= enq_item;
      end
   end

endmodule

`default_nettype wire

@@ design/rte_back.sv @@
// Back end: holds the matrix, runs loads, transforms and the rigid inverse in two stages.
`default_nettype none

module rte_back import rte_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      deq_valid,
   input  item_type  deq_item,
   output logic      deq_ready,
   rte_rsp_if.source rsp
);

   value_type mat_ff [ENTRIES];
   value_type mat_in [ENTRIES];

   // Multiply stage.
   logic      m_valid_ff, m_valid_in;
   logic      m_inv_ff, m_inv_in;
   term_type  m_term_ff [ROWS][ROWS];
   term_type  m_term_in [ROWS][ROWS];
   value_type m_init_ff [ROWS];
   value_type m_init_in [ROWS];

   // Result stage.
   logic      s_valid_ff, s_valid_in;
   coord_type s_x_ff, s_x_in;
   coord_type s_y_ff, s_y_in;
   coord_type s_z_ff, s_z_in;
   logic      s_ovf_ff, s_ovf_in;

   logic                       is_inv, is_load, s_free, m_done, issue_ok, issue;
   coord_type                  pt [ROWS];
   value_type                  a_op [ROWS][ROWS];
   logic signed [MUL_B_W-1:0]  b_op [ROWS][ROWS];
   logic signed [PROD_W-1:0]   prod [ROWS][ROWS];
   sum_type                    sum [ROWS];
   sat_type                    sat_res [ROWS];

   // Issue control. An inverse in the multiply stage holds back the next word until
   // it has rewritten the matrix.
   always_comb begin
      is_inv   = deq_item.func == FUNC_INVERSE;
      is_load  = deq_item.func == FUNC_LOAD;
      s_free   = !s_valid_ff || rsp.ready;
      m_done   = m_valid_ff && (m_inv_ff || s_free);
      issue_ok = !(m_valid_ff && m_inv_ff) && (is_load || !m_valid_ff || s_free);
      deq_ready = issue_ok;
      issue    = deq_valid && issue_ok;
   end

   // Operand selection and the nine multipliers.
   always_comb begin
      pt[0] = deq_item.x;
      pt[1] = deq_item.y;
      pt[2] = deq_item.z;
      for (int i = 0; i < ROWS; i++) begin
         for (int j = 0; j < ROWS; j++) begin
            if (is_inv) begin
               a_op[i][j] = mat_ff[j * COLS + i];
               b_op[i][j] = -MUL_B_W'(mat_ff[j * COLS + T_COL]);
            end else begin
               a_op[i][j] = mat_ff[i * COLS + j];
               b_op[i][j] = MUL_B_W'(pt[j]);
            end
            prod[i][j]      = PROD_W'(a_op[i][j]) * PROD_W'(b_op[i][j]);
            m_term_in[i][j] = prod[i][j][PROD_W-1:FRAC_BITS];
         end
         m_init_in[i] = (deq_item.func == FUNC_POINT) ? mat_ff[i * COLS + T_COL] : '0;
      end
      m_inv_in = is_inv;

      if (issue && !is_load) begin
         m_valid_in = 1'b1;
      end else if (m_done) begin
         m_valid_in = 1'b0;
      end else begin
         m_valid_in = m_valid_ff;
      end
   end

   // Sum and saturation of each row.
   always_comb begin
      for (int i = 0; i < ROWS; i++) begin
         sum[i] = SUM_W'(m_init_ff[i]) + SUM_W'(m_term_ff[i][0])
                + SUM_W'(m_term_ff[i][1]) + SUM_W'(m_term_ff[i][2]);
         sat_res[i] = sat_sum(sum[i]);
      end
      s_valid_in = s_free ? (m_valid_ff && !m_inv_ff) : s_valid_ff;
      s_x_in     = COORD_W'(sat_res[0].value);
      s_y_in     = COORD_W'(sat_res[1].value);
      s_z_in     = COORD_W'(sat_res[2].value);
      s_ovf_in   = sat_res[0].ovf || sat_res[1].ovf || sat_res[2].ovf;
   end

   // Matrix update: a finishing inverse or an issued load.
   always_comb begin
      mat_in = mat_ff;
      if (m_valid_ff && m_inv_ff) begin
         for (int i = 0; i < ROWS; i++) begin
            for (int j = 0; j < ROWS; j++) begin
               mat_in[i * COLS + j] = mat_ff[j * COLS + i];
            end
            mat_in[i * COLS + T_COL] = sat_res[i].value;
         end
      end else if (issue && is_load) begin
         mat_in[deq_item.idx] = deq_item.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ENTRIES; k++) begin
            mat_ff[k] <= ((k / COLS) == (k % COLS)) ? ONE_VALUE : '0;
         end
         m_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
      end else begin
         mat_ff     <= mat_in;
         m_valid_ff <= m_valid_in;
         s_valid_ff <= s_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue && !is_load) begin
         m_inv_ff  <= m_inv_in;
         m_term_ff <= m_term_in;
         m_init_ff <= m_init_in;
      end
      if (s_free) begin
         s_x_ff   <= s_x_in;
         s_y_ff   <= s_y_in;
         s_z_ff   <= s_z_in;
         s_ovf_ff <= s_ovf_in;
      end
   end

   always_comb begin
      rsp.valid    = s_valid_ff;
      rsp.out_x    = s_x_ff;
      rsp.out_y    = s_y_ff;
      rsp.out_z    = s_z_ff;
      rsp.overflow = s_ovf_ff;
   end

endmodule

`default_nettype wire

@@ design/rigid_transform_engine_top.sv @@
// Top level of the rigid transform engine: front end, word queue and execution back end.
//
//   channel   direction  handshake        payload
//   req_bus   in         valid / ready    func, row_index, col_index, entry_value,
//                                         point_x, point_y, point_z
//   rsp_bus   out        valid / ready    out_x, out_y, out_z, overflow
//
// A point or vector transform issues every cycle unless the response stalls or an inverse
// blocks issue. Its response passes through the queue, the multiply stage and the result
// register, each registered in turn. Loads give no response and bypass the multiply stage.
// A rigid inverse occupies the multiply stage and blocks issue while it rewrites the matrix.
// Reset is synchronous: the matrix returns to identity and the queue and both stages empty.
// When rsp_bus.ready is low the result register and the multiply stage hold; loads still
// issue, and the four-word queue keeps taking request words until it is full.
`default_nettype none

module rigid_transform_engine_top import rte_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rte_req_if.sink   req_bus,
   rte_rsp_if.source rsp_bus
);

   // Queue write side, fed by the front end.
   logic     enq_valid;
   logic     enq_ready;
   item_type enq_item;

   // Queue read side, drained by the back end.
   logic     deq_valid;
   logic     deq_ready;
   item_type deq_item;

   // The front end classifies each request word and throws away loads to a missing row.
   rte_front u_front (
      .req       (req_bus),
      .enq_valid (enq_valid),
      .enq_item  (enq_item),
      .enq_ready (enq_ready)
   );

   // The queue lets the front keep accepting while the back is stalled on the response.
   rte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .enq_valid (enq_valid),
      .enq_item  (enq_item),
      .enq_ready (enq_ready),
      .deq_valid (deq_valid),
      .deq_item  (deq_item),
      .deq_ready (deq_ready)
   );

   // The back end owns the matrix and executes every word strictly in order.
   rte_back u_back (
      .clock     (clock),
      .reset     (reset),
      .deq_valid (deq_valid),
      .deq_item  (deq_item),
      .deq_ready (deq_ready),
      .rsp       (rsp_bus)
   );

`ifndef SYNTHESIS
   // A load aimed at a row past the matrix is consumed without reaching the queue.
   a_drop_bad_row: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.func == FUNC_LOAD &&
       req_bus.row_index >= ROW_W'(ROWS)) |-> !enq_valid)
      else $error("load to a missing row entered the queue");

   // The word after an inverse must wait until the new matrix is written.
   a_inverse_blocks: assert property (@(posedge clock) disable iff (reset)
      (deq_valid && deq_ready && deq_item.func == FUNC_INVERSE) |=> !deq_ready)
      else $error("word issued while an inverse was still in flight");

   // A fresh response comes from an issued point or vector transform.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |->
         $past(deq_valid && deq_ready &&
               (deq_item.func == FUNC_POINT || deq_item.func == FUNC_VECTOR), 2))
      else $error("response without a matching transform");
`endif

endmodule

`default_nettype wire
